>>> rtl/core/picd_pkg.sv
// Shared constants, defaults and the queue item type of the column dominance block.
`timescale 1ns / 1ps
package picd_pkg;

  // Fixed widths of the external fields.
  localparam int MASK_W     = 64;
  localparam int TAG_W      = 16;
  localparam int IDX_OUT_W  = 6;
  localparam int TOTAL_W    = 7;
  localparam int ROWS_W     = 7;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [0:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd64;

  // Default sizes of the block.
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int TAG_BITS_DEF    = 16;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // One classified column on its way from the front to the back part.
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [TAG_W-1:0]  tag;
    logic              keep;  // column fits in the store
    logic              last;  // final column of the chart
  } picd_item_t;

endpackage

>>> rtl/core/picd_front.sv
// Front part: accepts columns and classifies them as stored or dropped.
`timescale 1ns / 1ps
module picd_front #(
  parameter int MaxColumns = picd_pkg::MAX_COLUMNS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [picd_pkg::MASK_W-1:0] coverage_mask_i,
  input  logic [picd_pkg::TAG_W-1:0]  column_tag_i,
  input  logic                        last_column_i,
  input  logic                        full_i,
  output logic                        q_push_o,
  output picd_pkg::picd_item_t        q_item_o
);
  import picd_pkg::*;

  localparam int CntW = $clog2(MaxColumns + 1);

  logic [CntW-1:0] fcnt_q, fcnt_d;
  logic            accept;
  logic            fits;

  // A column fits while fewer than the capacity have been taken for this chart.
  assign accept = push_i & ~full_i;
  assign fits   = (fcnt_q < CntW'(MaxColumns));

  assign q_push_o       = accept;
  assign q_item_o.mask  = coverage_mask_i;
  assign q_item_o.tag   = column_tag_i;
  assign q_item_o.keep  = fits;
  assign q_item_o.last  = last_column_i;

  // Column count of the current chart; the final column starts a new chart.
  always_comb begin
    fcnt_d = fcnt_q;
    if (accept) begin
      if (last_column_i) begin
        fcnt_d = '0;
      end else if (fits) begin
        fcnt_d = fcnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0;
    end else begin
      fcnt_q <= fcnt_d;
    end
  end

endmodule

>>> rtl/core/picd_queue.sv
// Short queue of classified columns between the front and back parts.
`timescale 1ns / 1ps
module picd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  picd_pkg::picd_item_t item_i,
  output logic                 full_o,
  output logic                 valid_o,
  output picd_pkg::picd_item_t item_o,
  input  logic                 pop_i
);
  import picd_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  picd_item_t      slots_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slots_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Storage of the queued columns.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/core/picd_back.sv
// Back part: column store, pairwise dominance sweep and survivor output.
`timescale 1ns / 1ps
module picd_back #(
  parameter int MaxColumns = picd_pkg::MAX_COLUMNS_DEF,
  parameter int MaxRows    = picd_pkg::MAX_ROWS_DEF,
  parameter int TagBits    = picd_pkg::TAG_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  picd_pkg::picd_item_t           q_item_i,
  output logic                           q_pop_o,
  input  logic [picd_pkg::ROWS_W-1:0]    rows_i,
  input  logic                           pop_i,
  output logic                           out_valid_o,
  output logic [picd_pkg::IDX_OUT_W-1:0] column_index_o,
  output logic [picd_pkg::TAG_W-1:0]     survivor_tag_o,
  output logic [picd_pkg::TOTAL_W-1:0]   survivors_total_o,
  output logic                           overflow_o,
  output logic                           last_result_o
);
  import picd_pkg::*;

  localparam int IdxW = $clog2(MaxColumns);
  localparam int CntW = $clog2(MaxColumns + 1);
  localparam int TagW = (TagBits < TAG_W) ? TagBits : TAG_W;

  typedef enum logic [5:0] {
    S_LOAD    = 6'b000001,
    S_FETCH   = 6'b000010,
    S_LATCH   = 6'b000100,
    S_SWEEP   = 6'b001000,
    S_EMIT_RD = 6'b010000,
    S_EMIT_WR = 6'b100000
  } back_state_e;

  back_state_e           state_q, state_d;
  logic [CntW-1:0]       ld_cnt_q, ld_cnt_d;
  logic                  ovf_q, ovf_d;
  logic [MaxColumns-1:0] alive_q, alive_d;
  logic [CntW-1:0]       b_q, b_d;
  logic [CntW-1:0]       a_q, a_d;
  logic                  cmp_v_q, cmp_v_d;
  logic                  keep_q, keep_d;
  logic [CntW-1:0]       total_q, total_d;
  logic [CntW-1:0]       i_q, i_d;
  logic [CntW-1:0]       k_q, k_d;
  logic [MaxRows-1:0]    mb_q, mb_d;

  logic                  out_v_q, out_v_d;
  logic [IdxW-1:0]       out_idx_q, out_idx_d;
  logic [TagW-1:0]       out_tag_q, out_tag_d;
  logic [CntW-1:0]       out_tot_q, out_tot_d;
  logic                  out_ovf_q, out_ovf_d;
  logic                  out_last_q, out_last_d;

  // Column memories with registered read data.
  logic [MaxRows-1:0]    mask_mem [MaxColumns];
  logic [TagW-1:0]       tag_mem  [MaxColumns];
  logic [MaxRows-1:0]    mrdata_q;
  logic [TagW-1:0]       trdata_q;
  logic                  mem_we, mrd_en, trd_en;
  logic [IdxW-1:0]       mrd_addr;

  logic [MaxRows-1:0]    rm;
  logic [MaxRows-1:0]    ma;
  logic                  covered;
  logic                  emit_go;

  // Rows at and above rows_in_use take no part in comparisons.
  always_comb begin
    for (int r = 0; r < MaxRows; r++) begin
      rm[r] = (rows_i > ROWS_W'(r));
    end
  end

  // Column b is removed when another column is a proper superset of it.
  assign ma      = mrdata_q & rm;
  assign covered = ((mb_q & ~ma) == '0) && (ma != mb_q);
  assign emit_go = ~out_v_q | pop_i;

  // Sequencer of load, sweep and emit.
  always_comb begin
    state_d    = state_q;
    ld_cnt_d   = ld_cnt_q;
    ovf_d      = ovf_q;
    alive_d    = alive_q;
    b_d        = b_q;
    a_d        = a_q;
    cmp_v_d    = 1'b0;
    keep_d     = keep_q;
    total_d    = total_q;
    i_d        = i_q;
    k_d        = k_q;
    mb_d       = mb_q;
    out_v_d    = out_v_q & ~pop_i;
    out_idx_d  = out_idx_q;
    out_tag_d  = out_tag_q;
    out_tot_d  = out_tot_q;
    out_ovf_d  = out_ovf_q;
    out_last_d = out_last_q;
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    mrd_en     = 1'b0;
    mrd_addr   = b_q[IdxW-1:0];
    trd_en     = 1'b0;
    case (state_q)
      S_LOAD: begin
        q_pop_o = q_valid_i;
        if (q_valid_i) begin
          if (q_item_i.keep) begin
            mem_we   = 1'b1;
            ld_cnt_d = ld_cnt_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (q_item_i.last) begin
            b_d     = '0;
            total_d = '0;
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        mrd_en   = 1'b1;
        mrd_addr = b_q[IdxW-1:0];
        state_d  = S_LATCH;
      end
      S_LATCH: begin
        mb_d    = mrdata_q & rm;
        keep_d  = 1'b1;
        a_d     = '0;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        // One stored column is read per cycle and compared in the next cycle.
        if (a_q != ld_cnt_q) begin
          mrd_en   = 1'b1;
          mrd_addr = a_q[IdxW-1:0];
          a_d      = a_q + CntW'(1);
          cmp_v_d  = 1'b1;
        end
        if (cmp_v_q && covered) begin
          keep_d = 1'b0;
        end
        if ((a_q == ld_cnt_q) && !cmp_v_q) begin
          alive_d[b_q[IdxW-1:0]] = keep_q;
          total_d = total_q + CntW'(keep_q);
          if ((b_q + CntW'(1)) == ld_cnt_q) begin
            i_d     = '0;
            k_d     = '0;
            state_d = S_EMIT_RD;
          end else begin
            b_d     = b_q + CntW'(1);
            state_d = S_FETCH;
          end
        end
      end
      S_EMIT_RD: begin
        if (i_q == ld_cnt_q) begin
          // Chart finished: back to an empty store.
          alive_d  = '1;
          ld_cnt_d = '0;
          ovf_d    = 1'b0;
          state_d  = S_LOAD;
        end else if (alive_q[i_q[IdxW-1:0]]) begin
          trd_en  = 1'b1;
          state_d = S_EMIT_WR;
        end else begin
          i_d = i_q + CntW'(1);
        end
      end
      S_EMIT_WR: begin
        if (emit_go) begin
          out_v_d    = 1'b1;
          out_idx_d  = i_q[IdxW-1:0];
          out_tag_d  = trdata_q;
          out_tot_d  = total_q;
          out_ovf_d  = ovf_q;
          out_last_d = ((k_q + CntW'(1)) == total_q);
          k_d        = k_q + CntW'(1);
          i_d        = i_q + CntW'(1);
          state_d    = S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      ld_cnt_q <= '0;
      ovf_q    <= 1'b0;
      alive_q  <= '1;
      b_q      <= '0;
      a_q      <= '0;
      cmp_v_q  <= 1'b0;
      keep_q   <= 1'b1;
      total_q  <= '0;
      i_q      <= '0;
      k_q      <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ld_cnt_q <= ld_cnt_d;
      ovf_q    <= ovf_d;
      alive_q  <= alive_d;
      b_q      <= b_d;
      a_q      <= a_d;
      cmp_v_q  <= cmp_v_d;
      keep_q   <= keep_d;
      total_q  <= total_d;
      i_q      <= i_d;
      k_q      <= k_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mb_q       <= mb_d;
    out_idx_q  <= out_idx_d;
    out_tag_q  <= out_tag_d;
    out_tot_q  <= out_tot_d;
    out_ovf_q  <= out_ovf_d;
    out_last_q <= out_last_d;
  end

  // Mask memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mask_mem[ld_cnt_q[IdxW-1:0]] <= q_item_i.mask[MaxRows-1:0];
    end
    if (mrd_en) begin
      mrdata_q <= mask_mem[mrd_addr];
    end
  end

  // Tag memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[ld_cnt_q[IdxW-1:0]] <= q_item_i.tag[TagW-1:0];
    end
    if (trd_en) begin
      trdata_q <= tag_mem[i_q[IdxW-1:0]];
    end
  end

  assign out_valid_o       = out_v_q;
  assign column_index_o    = IDX_OUT_W'(out_idx_q);
  assign survivor_tag_o    = TAG_W'(out_tag_q);
  assign survivors_total_o = TOTAL_W'(out_tot_q);
  assign overflow_o        = out_ovf_q;
  assign last_result_o     = out_last_q;

  // The store is fully alive whenever columns are being loaded.
  a_alive_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (&alive_q))
    else $error("alive flags not restored before loading");

  // The sweep never reads past the loaded columns.
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (a_q <= ld_cnt_q))
    else $error("sweep index beyond loaded columns");

  // No more survivors are emitted than were counted.
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT_WR) && emit_go) |-> (k_q < total_q))
    else $error("survivor emitted beyond total");

  // The store count stays within capacity.
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_cnt_q <= CntW'(MaxColumns))
    else $error("column count beyond capacity");

endmodule

>>> rtl/core/prime_implicant_column_dominance.sv
// An accepted column passes through the queue and is then written to the store; one column a
// cycle while full is low. After the final column, the sweep compares each stored column with
// all stored columns, one memory read per pairwise check; emission then reads the tag of each
// survivor and outputs it, skips each removed column, and closes the chart. Columns of the next
// chart wait in the queue, and then behind full, until the back part has closed the chart.
// Reset clears counters and output valid, sets all alive flags, sets rows_in_use to 64; memories untouched.
`timescale 1ns / 1ps
module prime_implicant_column_dominance #(
  parameter int MaxColumns = picd_pkg::MAX_COLUMNS_DEF,
  parameter int MaxRows    = picd_pkg::MAX_ROWS_DEF,
  parameter int TagBits    = picd_pkg::TAG_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [picd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [picd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [picd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  // Column input
  input  logic                            push,
  output logic                            full,
  input  logic [picd_pkg::MASK_W-1:0]     coverage_mask_i,
  input  logic [picd_pkg::TAG_W-1:0]      column_tag_i,
  input  logic                            last_column_i,
  // Survivor output
  output logic                            empty,
  input  logic                            pop,
  output logic [picd_pkg::IDX_OUT_W-1:0]  column_index_o,
  output logic [picd_pkg::TAG_W-1:0]      survivor_tag_o,
  output logic [picd_pkg::TOTAL_W-1:0]    survivors_total_o,
  output logic                            overflow_o,
  output logic                            last_result_o
);
  import picd_pkg::*;

  logic [ROWS_W-1:0] rows_q;
  logic              cfg_wr;
  logic [0:0]        reg_sel;
  logic              q_push, q_full, q_valid, q_pop, out_valid;
  picd_item_t        q_in, q_out;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign prdata  = (reg_sel == REG_ROWS_IN_USE) ? APB_DATA_W'(rows_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
    end else if (cfg_wr && (reg_sel == REG_ROWS_IN_USE)) begin
      rows_q <= pwdata[ROWS_W-1:0];
    end
  end

  picd_front #(
    .MaxColumns(MaxColumns)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .coverage_mask_i(coverage_mask_i),
    .column_tag_i   (column_tag_i),
    .last_column_i  (last_column_i),
    .full_i         (q_full),
    .q_push_o       (q_push),
    .q_item_o       (q_in)
  );

  assign full = q_full;

  picd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .full_o (q_full),
    .valid_o(q_valid),
    .item_o (q_out),
    .pop_i  (q_pop)
  );

  picd_back #(
    .MaxColumns(MaxColumns),
    .MaxRows   (MaxRows),
    .TagBits   (TagBits)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_out),
    .q_pop_o          (q_pop),
    .rows_i           (rows_q),
    .pop_i            (pop),
    .out_valid_o      (out_valid),
    .column_index_o   (column_index_o),
    .survivor_tag_o   (survivor_tag_o),
    .survivors_total_o(survivors_total_o),
    .overflow_o       (overflow_o),
    .last_result_o    (last_result_o)
  );

  assign empty = ~out_valid;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the prime implicant column dominance block.
`timescale 1ns / 1ps
module tb_top;

  localparam int          MAX_COLUMNS    = picd_pkg::MAX_COLUMNS_DEF;
  localparam int          MAX_ROWS       = picd_pkg::MAX_ROWS_DEF;
  localparam int          RANDOM_COLUMNS = 480;
  localparam int          PHASE_COLUMNS  = RANDOM_COLUMNS / 3;
  localparam int          HOLDOFF_CYCLES = 500;
  localparam int          CLOSE_CYCLES   = 16;
  localparam int          END_CYCLES     = 64;
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam logic [picd_pkg::APB_ADDR_W-1:0] ROWS_ADDR = {picd_pkg::REG_ROWS_IN_USE, 2'b00};

  // One surviving column as the block should report it.
  typedef struct {
    logic [picd_pkg::IDX_OUT_W-1:0] index;
    logic [picd_pkg::TAG_W-1:0]     tag;
    logic [picd_pkg::TOTAL_W-1:0]   total;
    logic                           overflow;
    logic                           closing;
  } survivor_t;

  // Keeps its own copy of the chart, reduces it on the final column and
  // holds the survivors that the block still owes.
  class dominance_tracker;
    logic [picd_pkg::ROWS_W-1:0] rows_in_use;
    logic [picd_pkg::MASK_W-1:0] masks [MAX_COLUMNS];
    logic [picd_pkg::TAG_W-1:0]  tags [MAX_COLUMNS];
    int unsigned                 loaded;
    bit                          dropped;
    survivor_t                   expected_survivors [$];
    int unsigned                 failures;

    function new();
      rows_in_use = picd_pkg::ROWS_RESET;
      loaded      = 0;
      dropped     = 1'b0;
      failures    = 0;
    endfunction

    function void set_rows(logic [31:0] word);
      rows_in_use = word[picd_pkg::ROWS_W-1:0];
    endfunction

    function int unsigned pending();
      return expected_survivors.size();
    endfunction

    // Stores the column, and on the final one works out the survivors.
    function void load_column(logic [picd_pkg::MASK_W-1:0] mask,
                              logic [picd_pkg::TAG_W-1:0] tag, logic last);
      logic [picd_pkg::MASK_W-1:0] row_span;
      logic [picd_pkg::MASK_W-1:0] seen [MAX_COLUMNS];
      int unsigned                 weight [MAX_COLUMNS];
      bit                          alive [MAX_COLUMNS];
      int unsigned                 total;
      int unsigned                 rank;
      survivor_t                   s;
      if (loaded < MAX_COLUMNS) begin
        masks[loaded] = mask;
        tags[loaded]  = tag;
        loaded++;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;

      // Rows beyond the configured count take no part in the comparison.
      row_span = (rows_in_use >= MAX_ROWS) ? '1 : ((64'd1 << rows_in_use) - 64'd1);
      for (int i = 0; i < loaded; i++) begin
        seen[i]   = masks[i] & row_span;
        weight[i] = $countones(seen[i]);
      end

      // A column falls when another one covers all its rows and more.
      total = 0;
      for (int b = 0; b < loaded; b++) begin
        alive[b] = 1'b1;
        for (int a = 0; a < loaded; a++) begin
          if (a != b && (seen[b] & ~seen[a]) == '0 && weight[a] > weight[b]) alive[b] = 1'b0;
        end
        if (alive[b]) total++;
      end

      rank = 0;
      for (int i = 0; i < loaded; i++) begin
        if (alive[i]) begin
          rank++;
          s.index    = picd_pkg::IDX_OUT_W'(i);
          s.tag      = tags[i];
          s.total    = picd_pkg::TOTAL_W'(total);
          s.overflow = dropped;
          s.closing  = (rank == total);
          expected_survivors.push_back(s);
        end
      end
      loaded  = 0;
      dropped = 1'b0;
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    // Compares one accepted survivor with the oldest one still owed.
    function void check_survivor(logic [picd_pkg::IDX_OUT_W-1:0] index,
                                 logic [picd_pkg::TAG_W-1:0] tag,
                                 logic [picd_pkg::TOTAL_W-1:0] total,
                                 logic overflow, logic closing);
      survivor_t want;
      if (expected_survivors.size() == 0) begin
        $error("survivor with no chart reduced: column_index %0d, survivor_tag %0d",
               index, tag);
        failures++;
        return;
      end
      want = expected_survivors.pop_front();
      compare_field("column_index", 16'(want.index), 16'(index));
      compare_field("survivor_tag", want.tag, tag);
      compare_field("survivors_total", 16'(want.total), 16'(total));
      compare_field("overflow", 16'(want.overflow), 16'(overflow));
      compare_field("last_result", 16'(want.closing), 16'(closing));
    endfunction
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [picd_pkg::APB_ADDR_W-1:0]    paddr = '0;
  logic [picd_pkg::APB_DATA_W-1:0]    pwdata = '0;
  logic [picd_pkg::APB_DATA_W-1:0]    prdata;
  logic                               pready;
  logic                               push = 1'b0;
  logic                               full;
  logic [picd_pkg::MASK_W-1:0]        coverage_mask_i = '0;
  logic [picd_pkg::TAG_W-1:0]         column_tag_i = '0;
  logic                               last_column_i = 1'b0;
  logic                               empty;
  logic                               pop = 1'b0;
  logic [picd_pkg::IDX_OUT_W-1:0]     column_index_o;
  logic [picd_pkg::TAG_W-1:0]         survivor_tag_o;
  logic [picd_pkg::TOTAL_W-1:0]       survivors_total_o;
  logic                               overflow_o;
  logic                               last_result_o;

  dominance_tracker tracker;
  int unsigned      sender_idle_pct = 38;
  int unsigned      receiver_idle_pct = 60;
  int unsigned      stall_orders = 0;
  int unsigned      stalls_served = 0;
  int unsigned      pop_hold_left = 0;
  int unsigned      columns_accepted = 0;
  int unsigned      sparse_rows = 8;
  int unsigned      cycle_count = 0;

  prime_implicant_column_dominance dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .push              (push),
    .full              (full),
    .coverage_mask_i   (coverage_mask_i),
    .column_tag_i      (column_tag_i),
    .last_column_i     (last_column_i),
    .empty             (empty),
    .pop               (pop),
    .column_index_o    (column_index_o),
    .survivor_tag_o    (survivor_tag_o),
    .survivors_total_o (survivors_total_o),
    .overflow_o        (overflow_o),
    .last_result_o     (last_result_o)
  );

  // Clock generation.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Survivor side: checks each accepted request, then decides whether to pop.
  // A stall order from the stimulus holds pop low for a long stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        tracker.check_survivor(column_index_o, survivor_tag_o, survivors_total_o,
                               overflow_o, last_result_o);
      end
      if (stall_orders != stalls_served) begin
        stalls_served <= stalls_served + 1;
        pop_hold_left <= HOLDOFF_CYCLES;
        pop           <= 1'b0;
      end else if (pop_hold_left != 0) begin
        pop_hold_left <= pop_hold_left - 1;
        pop           <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Next mask of a chart, often a subset, superset or copy of the one before
  // so that dominance actually happens.
  function automatic logic [picd_pkg::MASK_W-1:0] next_mask(logic [picd_pkg::MASK_W-1:0] prev);
    logic [picd_pkg::MASK_W-1:0] wide;
    logic [picd_pkg::MASK_W-1:0] region;
    int unsigned                 pick;
    wide   = {$urandom, $urandom};
    region = (sparse_rows >= 64) ? '1 : ((64'd1 << sparse_rows) - 64'd1);
    pick   = $urandom_range(99);
    if (pick < 20) return wide;
    if (pick < 45) return prev & wide;
    if (pick < 65) return prev | (64'd1 << $urandom_range(63));
    if (pick < 75) return prev;
    return wide & {$urandom, $urandom} & region;
  endfunction

  // Offers one column request and waits until the block takes it.
  task automatic send_column(input logic [picd_pkg::MASK_W-1:0] mask,
                             input logic [picd_pkg::TAG_W-1:0] tag, input logic last);
    push            <= 1'b1;
    coverage_mask_i <= mask;
    column_tag_i    <= tag;
    last_column_i   <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tracker.load_column(mask, tag, last);
    columns_accepted++;
    // Random gap before the next request.
    if ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic send_chart(input int unsigned columns);
    logic [picd_pkg::MASK_W-1:0] mask;
    mask = {$urandom, $urandom};
    for (int unsigned c = 0; c < columns; c++) begin
      mask = next_mask(mask);
      send_column(mask, picd_pkg::TAG_W'($urandom), c == columns - 1);
    end
  endtask

  // Holds the sender until every survivor is in, then lets the chart close.
  task automatic wait_for_survivors();
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (CLOSE_CYCLES) @(posedge clk_i);
  endtask

  // Register write with setup and access cycles; upper data bits are noise.
  task automatic write_rows(input logic [picd_pkg::ROWS_W-1:0] rows);
    logic [31:0] word;
    word    = {25'($urandom), rows};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROWS_ADDR;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_rows(word);
    sparse_rows = (rows >= 1 && rows <= MAX_ROWS) ? rows : 8;
  endtask

  function automatic logic [picd_pkg::ROWS_W-1:0] pick_rows();
    case ($urandom_range(9))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd127;
      4:       return 7'($urandom_range(65, 126));
      5:       return 7'($urandom_range(9, 63));
      default: return 7'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic int unsigned pick_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) return $urandom_range(62, 68);
    if (pick < 10) return $urandom_range(16, 40);
    return $urandom_range(1, 10);
  endfunction

  // Stimulus: reset, directed charts, then random charts in three idling phases.
  initial begin
    int unsigned random_start;
    int unsigned charts_left;
    tracker = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The all-ones column covers every other one.
    send_column('1, 16'hFFFF, 1'b0);
    send_column('0, 16'h0000, 1'b0);
    send_column(64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 1'b0);
    send_column(64'h5555_5555_5555_5555, 16'hAAAA, 1'b1);
    // A chart of a single column.
    send_column(64'h8000_0000_0000_0001, 16'h1234, 1'b1);
    // Identical columns must not remove each other.
    send_column(64'hF0, 16'($urandom), 1'b0);
    send_column(64'hF0, 16'($urandom), 1'b0);
    send_column(64'h0F, 16'($urandom), 1'b1);

    // Few rows: high bits are ignored, so the first column compares as empty.
    wait_for_survivors();
    write_rows(7'd4);
    send_column(64'hFFFF_FFFF_FFFF_FFF0, 16'($urandom), 1'b0);
    send_column(64'h1, 16'($urandom), 1'b0);
    send_column(64'h3, 16'($urandom), 1'b1);

    // No rows at all: every column survives.
    wait_for_survivors();
    write_rows(7'd0);
    send_column(64'h1, 16'($urandom), 1'b0);
    send_column(64'h3, 16'($urandom), 1'b0);
    send_column(64'hFF, 16'($urandom), 1'b1);

    // A row count above the maximum acts as the maximum.
    wait_for_survivors();
    write_rows(7'd127);
    send_column('1, 16'($urandom), 1'b0);
    send_column(64'h8000_0000_0000_0000, 16'($urandom), 1'b1);

    // One row only.
    wait_for_survivors();
    write_rows(7'd1);
    send_column(64'h2, 16'($urandom), 1'b0);
    send_column(64'h3, 16'($urandom), 1'b0);
    send_column(64'h1, 16'($urandom), 1'b1);

    // Random charts. The first phase starts with a long receiver hold-off
    // while charts keep coming, so the block backs up and raises full.
    wait_for_survivors();
    write_rows(7'd6);
    random_start = columns_accepted;
    stall_orders <= stall_orders + 1;
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   = (phase == 0) ? 38 : (phase == 1) ? 60 : 0;
      receiver_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 38 : 0;
      charts_left = $urandom_range(3, 8);
      // The second phase opens with a chart whose final column is dropped.
      if (phase == 1) begin
        wait_for_survivors();
        write_rows(7'd64);
        send_chart(MAX_COLUMNS + 1);
      end
      while (columns_accepted - random_start < (phase + 1) * PHASE_COLUMNS) begin
        if (charts_left == 0) begin
          wait_for_survivors();
          write_rows(pick_rows());
          charts_left = $urandom_range(3, 8);
        end
        send_chart(pick_size());
        charts_left--;
      end
    end

    // Drain and finish.
    wait_for_survivors();
    repeat (END_CYCLES) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
